/* rtl/core/fcat_pkg.sv */
// ----------------------------------------------------------------------------
// fcat_pkg
// Shared types, constants and the arctangent table for the full-circle
// arctangent pipeline.
// ----------------------------------------------------------------------------
package fcat_pkg;

  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int N_CELLS    = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int IW         = $clog2(TABLE_LEN);

  localparam int IN_W  = 16;
  localparam int MAG_W = IN_W + 1;
  localparam int FRAC  = 16;
  localparam int XW    = MAG_W + FRAC + 2;
  localparam int ZW    = 19;
  localparam int ANG_W = 16;

  localparam logic [ANG_W-1:0] ANG_HALF_PI       = 16'd12868;
  localparam logic [ANG_W-1:0] ANG_PI            = 16'd25736;
  localparam logic [ANG_W-1:0] ANG_THREE_HALF_PI = 16'd38604;
  localparam logic [ANG_W:0]   ANG_TWO_PI        = 17'd51472;
  localparam logic signed [ZW-1:0] ACC_HALF_PI   = 19'sd102944;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_HALF_PI,
    CLS_PI,
    CLS_THREE_HALF_PI,
    CLS_Q1,
    CLS_Q2,
    CLS_Q3,
    CLS_Q4
  } cls_t;

  typedef struct packed {
    logic                 vld;
    cls_t                 cls;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  // atan(2^-i) * 65536, rounded
  function automatic logic signed [ZW-1:0] atan_step(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 19'sd51472;
      5'd1:    r = 19'sd30386;
      5'd2:    r = 19'sd16055;
      5'd3:    r = 19'sd8150;
      5'd4:    r = 19'sd4091;
      5'd5:    r = 19'sd2047;
      5'd6:    r = 19'sd1024;
      5'd7:    r = 19'sd512;
      5'd8:    r = 19'sd256;
      5'd9:    r = 19'sd128;
      5'd10:   r = 19'sd64;
      5'd11:   r = 19'sd32;
      5'd12:   r = 19'sd16;
      5'd13:   r = 19'sd8;
      5'd14:   r = 19'sd4;
      5'd15:   r = 19'sd2;
      5'd16:   r = 19'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/full_circle_arctangent_top.sv */
// ----------------------------------------------------------------------------
// full_circle_arctangent_top
// Full-circle arctangent: angle of (horiz, vert) in [0, 2*pi), unsigned
// Q3.13 radians, through a chain of CORDIC vectoring cells.
//
//   channel  | signals                | handshake
//   ---------+------------------------+------------------------------
//   request  | vert[15:0], horiz[15:0] | start & !busy
//   result   | angle[15:0]            | done, one cycle, no stall
//
// One request per cycle; busy is never raised. The pipeline is an input
// stage, one cell per rotation, and an output stage. Synchronous reset
// clears only the valid pipeline; results in flight at reset are dropped.
// ----------------------------------------------------------------------------
module full_circle_arctangent_top
  import fcat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] vert,
  input  logic signed [IN_W-1:0] horiz,
  output logic                   done,
  output logic [ANG_W-1:0]       angle
);

  cell_t chain [N_CELLS+1];

  assign busy = 1'b0;

  fcat_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .vert  (vert),
    .horiz (horiz),
    .dout  (chain[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    fcat_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IW'(g)),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  fcat_back u_back (
    .clk   (clk),
    .rst   (rst),
    .din   (chain[N_CELLS]),
    .done  (done),
    .angle (angle)
  );

endmodule

/* rtl/core/fcat_front.sv */
// ----------------------------------------------------------------------------
// fcat_front
// Classifies the request by axis/quadrant and folds it into the first
// quadrant as scaled magnitudes.
// ----------------------------------------------------------------------------
module fcat_front
  import fcat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [IN_W-1:0] vert,
  input  logic signed [IN_W-1:0] horiz,
  output cell_t                  dout
);

  logic [MAG_W-1:0] vmag;
  logic [MAG_W-1:0] hmag;
  cls_t             cls_next;

  always_comb begin
    vmag = vert[IN_W-1]  ? MAG_W'(-{vert[IN_W-1], vert})   : MAG_W'({vert[IN_W-1], vert});
    hmag = horiz[IN_W-1] ? MAG_W'(-{horiz[IN_W-1], horiz}) : MAG_W'({horiz[IN_W-1], horiz});
    if (vert == '0 && horiz == '0) begin
      cls_next = CLS_ZERO;
    end else if (vert == '0 && !horiz[IN_W-1]) begin
      cls_next = CLS_ZERO;
    end else if (horiz == '0 && !vert[IN_W-1]) begin
      cls_next = CLS_HALF_PI;
    end else if (vert == '0) begin
      cls_next = CLS_PI;
    end else if (horiz == '0) begin
      cls_next = CLS_THREE_HALF_PI;
    end else if (!vert[IN_W-1] && !horiz[IN_W-1]) begin
      cls_next = CLS_Q1;
    end else if (!vert[IN_W-1]) begin
      cls_next = CLS_Q2;
    end else if (horiz[IN_W-1]) begin
      cls_next = CLS_Q3;
    end else begin
      cls_next = CLS_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= start;
    end
    dout.cls <= cls_next;
    dout.x   <= {2'b00, hmag, {FRAC{1'b0}}};
    dout.y   <= {2'b00, vmag, {FRAC{1'b0}}};
    dout.z   <= '0;
  end

endmodule

/* rtl/core/fcat_cell.sv */
// ----------------------------------------------------------------------------
// fcat_cell
// One CORDIC vectoring rotation with its pipeline register.
// ----------------------------------------------------------------------------
module fcat_cell
  import fcat_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [IW-1:0] idx,
  input  cell_t         din,
  output cell_t         dout
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = din.x >>> idx;
  assign ys = din.y >>> idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.cls <= din.cls;
    if (!din.y[XW-1]) begin
      dout.x <= din.x + ys;
      dout.y <= din.y - xs;
      dout.z <= din.z + atan_step(idx);
    end else begin
      dout.x <= din.x - ys;
      dout.y <= din.y + xs;
      dout.z <= din.z - atan_step(idx);
    end
  end

endmodule

/* rtl/core/fcat_back.sv */
// ----------------------------------------------------------------------------
// fcat_back
// Clamps and rounds the accumulated angle to Q3.13 and restores the
// quadrant; registers the result and its strobe.
// ----------------------------------------------------------------------------
module fcat_back
  import fcat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_t            din,
  output logic             done,
  output logic [ANG_W-1:0] angle
);

  logic [ZW-2:0]    zc;
  logic [ZW-1:0]    zr;
  logic [ANG_W-1:0] t;
  logic [ANG_W:0]   a;
  logic [ANG_W-1:0] angle_next;

  always_comb begin
    if (din.z[ZW-1]) begin
      zc = '0;
    end else if (din.z > ACC_HALF_PI) begin
      zc = (ZW-1)'(ACC_HALF_PI);
    end else begin
      zc = din.z[ZW-2:0];
    end
    zr = ZW'(zc) + ZW'(4);
    t  = ANG_W'(zr >> 3);
    if (t > ANG_HALF_PI) begin
      t = ANG_HALF_PI;
    end
    case (din.cls)
      CLS_ZERO:          a = '0;
      CLS_HALF_PI:       a = {1'b0, ANG_HALF_PI};
      CLS_PI:            a = {1'b0, ANG_PI};
      CLS_THREE_HALF_PI: a = {1'b0, ANG_THREE_HALF_PI};
      CLS_Q1:            a = {1'b0, t};
      CLS_Q2:            a = {1'b0, ANG_PI} - {1'b0, t};
      CLS_Q3:            a = {1'b0, ANG_PI} + {1'b0, t};
      default:           a = ANG_TWO_PI - {1'b0, t};
    endcase
    if (a >= ANG_TWO_PI) begin
      angle_next = ANG_W'(a - ANG_TWO_PI);
    end else begin
      angle_next = a[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.vld;
    end
    angle <= angle_next;
  end

endmodule
